### hw/rtl/h4d_pkg.sv
// H4 deframer package: packet type and verdict codes, magic table, result beat struct.
// No dependencies.
`timescale 1ns / 1ps

package h4d_pkg;

  localparam logic [2:0] TYPE_NONE  = 3'd0;
  localparam logic [2:0] TYPE_CMD   = 3'd1;
  localparam logic [2:0] TYPE_ACL   = 3'd2;
  localparam logic [2:0] TYPE_SCO   = 3'd3;
  localparam logic [2:0] TYPE_EVT   = 3'd4;
  localparam logic [2:0] TYPE_NEG   = 3'd6;
  localparam logic [2:0] TYPE_ALIVE = 3'd7;

  localparam logic [3:0] VERD_FORWARD    = 4'd0;
  localparam logic [3:0] VERD_VEND_ACK   = 4'd1;
  localparam logic [3:0] VERD_VEND_UNK   = 4'd2;
  localparam logic [3:0] VERD_NEG_OK     = 4'd3;
  localparam logic [3:0] VERD_NEG_BAD    = 4'd4;
  localparam logic [3:0] VERD_ALIVE_OK   = 4'd5;
  localparam logic [3:0] VERD_ALIVE_BAD  = 4'd6;
  localparam logic [3:0] VERD_HOST_EVT   = 4'd7;
  localparam logic [3:0] VERD_DROPPED    = 4'd8;

  localparam int unsigned IDX_W = 17;
  localparam int unsigned HDR_W = 9;

  localparam logic [HDR_W-1:0] HDR_UNKNOWN = '1;
  localparam logic [IDX_W-1:0] PKT_UNKNOWN = '1;

  localparam logic [15:0] OPC_VENDOR_PAD = 16'hfc00;
  localparam logic [5:0]  OGF_VENDOR     = 6'h3f;
  localparam logic [9:0]  OCF_ACK_A      = 10'h10c;
  localparam logic [9:0]  OCF_ACK_B      = 10'h12b;
  localparam logic [7:0]  ALIVE_BYTE2    = 8'h55;
  localparam logic [7:0]  ALIVE_BYTE3    = 8'h00;
  localparam logic [HDR_W-1:0] NEG_MAGIC_LEN = 9'd12;

  typedef struct packed {
    logic [7:0]       byte_out;
    logic [2:0]       packet_type;
    logic [IDX_W-1:0] byte_index;
    logic             in_header;
    logic             is_last;
    logic [3:0]       verdict;
  } result_t;

  function automatic logic [7:0] neg_magic(input logic [3:0] pos);
    logic [7:0] val;
    case (pos)
      4'd0:    val = 8'h06;
      4'd1:    val = 8'h0a;
      4'd2:    val = 8'h00;
      4'd3:    val = 8'ha0;
      4'd4:    val = 8'h01;
      4'd5:    val = 8'h00;
      4'd6:    val = 8'h00;
      4'd7:    val = 8'h4c;
      4'd8:    val = 8'h00;
      4'd9:    val = 8'h96;
      4'd10:   val = 8'h00;
      4'd11:   val = 8'h00;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic known_type(input logic [7:0] b);
    return b == 8'(TYPE_CMD) || b == 8'(TYPE_ACL) || b == 8'(TYPE_SCO) ||
           b == 8'(TYPE_EVT) || b == 8'(TYPE_NEG) || b == 8'(TYPE_ALIVE);
  endfunction

endpackage

### hw/rtl/h4d_decoder.sv
// H4 deframer packet tracker: per-packet state registers and the byte decode.
// Depends on h4d_pkg.
`timescale 1ns / 1ps

module h4d_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [7:0]       data_byte,
  output h4d_pkg::result_t res
);
  import h4d_pkg::*;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       type_r, type_nxt;
  logic [HDR_W-1:0] hdr_r, hdr_nxt;
  logic [IDX_W-1:0] pkt_r, pkt_nxt;
  logic [15:0]      opc_r, opc_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic             magic_r, magic_nxt;
  logic             alive_r, alive_nxt;

  logic [IDX_W:0]   n_ext;
  logic [15:0]      dlen;
  logic [8:0]       pad_len;
  logic             first;
  logic             last;
  logic [3:0]       verd;

  assign first   = (cnt_r == '0);
  assign n_ext   = {1'b0, cnt_r} + 18'd1;
  assign pad_len = ({1'b0, data_byte} + 9'd1) & ~9'd1;

  always_comb begin
    type_nxt   = type_r;
    hdr_nxt    = hdr_r;
    pkt_nxt    = pkt_r;
    opc_nxt    = opc_r;
    len_lo_nxt = len_lo_r;
    magic_nxt  = magic_r;
    alive_nxt  = alive_r;
    dlen       = '0;
    if (first) begin
      type_nxt   = data_byte[2:0];
      hdr_nxt    = HDR_UNKNOWN;
      pkt_nxt    = PKT_UNKNOWN;
      opc_nxt    = '0;
      len_lo_nxt = '0;
      magic_nxt  = (data_byte == neg_magic(4'd0));
      alive_nxt  = 1'b1;
    end else begin
      if (cnt_r == 17'd1) opc_nxt[7:0] = data_byte;
      if (cnt_r == 17'd2) opc_nxt[15:8] = data_byte;
      if (cnt_r == 17'd3) len_lo_nxt = data_byte;
      if (cnt_r >= 17'd12 || data_byte != neg_magic(cnt_r[3:0])) magic_nxt = 1'b0;
      if ((cnt_r == 17'd2 && data_byte != ALIVE_BYTE2) ||
          (cnt_r == 17'd3 && data_byte != ALIVE_BYTE3)) alive_nxt = 1'b0;
      if (cnt_r == 17'd1) begin
        case (type_r)
          TYPE_CMD: hdr_nxt = 9'd4;
          TYPE_EVT: hdr_nxt = 9'd3;
          TYPE_ACL: hdr_nxt = 9'd5;
          TYPE_SCO: hdr_nxt = 9'd4;
          TYPE_NEG: hdr_nxt = {1'b0, data_byte} + 9'd2;
          default:  hdr_nxt = 9'd4;
        endcase
      end
      case (type_r)
        TYPE_CMD: dlen = (opc_nxt == OPC_VENDOR_PAD) ? {7'd0, pad_len} : {8'd0, data_byte};
        TYPE_EVT: dlen = {8'd0, data_byte};
        TYPE_ACL: dlen = {data_byte, len_lo_nxt};
        TYPE_SCO: dlen = {8'd0, data_byte};
        default:  dlen = '0;
      endcase
      if (n_ext == {9'd0, hdr_nxt}) pkt_nxt = {8'd0, hdr_nxt} + {1'b0, dlen};
    end
  end

  assign last = !first && (n_ext == {1'b0, pkt_nxt});

  always_comb begin
    case (type_r)
      TYPE_CMD: begin
        if (opc_nxt[15:10] == OGF_VENDOR) begin
          verd = (opc_nxt[9:0] == OCF_ACK_A || opc_nxt[9:0] == OCF_ACK_B) ?
                 VERD_VEND_ACK : VERD_VEND_UNK;
        end else begin
          verd = VERD_FORWARD;
        end
      end
      TYPE_EVT:   verd = VERD_HOST_EVT;
      TYPE_NEG:   verd = (hdr_nxt == NEG_MAGIC_LEN && magic_nxt) ? VERD_NEG_OK : VERD_NEG_BAD;
      TYPE_ALIVE: verd = alive_nxt ? VERD_ALIVE_OK : VERD_ALIVE_BAD;
      default:    verd = VERD_FORWARD;
    endcase
  end

  always_comb begin
    res.byte_out   = data_byte;
    res.byte_index = cnt_r;
    if (first) begin
      res.in_header = 1'b1;
      if (known_type(data_byte)) begin
        res.packet_type = data_byte[2:0];
        res.is_last     = 1'b0;
        res.verdict     = VERD_FORWARD;
      end else begin
        res.packet_type = TYPE_NONE;
        res.is_last     = 1'b1;
        res.verdict     = VERD_DROPPED;
      end
    end else begin
      res.packet_type = type_r;
      res.in_header   = (cnt_r < {8'd0, hdr_nxt});
      res.is_last     = last;
      res.verdict     = last ? verd : VERD_FORWARD;
    end
  end

  always_comb begin
    if (first) begin
      cnt_nxt = known_type(data_byte) ? 17'd1 : '0;
    end else if (last) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = n_ext[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      type_r   <= TYPE_NONE;
      hdr_r    <= HDR_UNKNOWN;
      pkt_r    <= PKT_UNKNOWN;
      opc_r    <= '0;
      len_lo_r <= '0;
      magic_r  <= 1'b1;
      alive_r  <= 1'b1;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
      // drop an unknown type byte without touching packet state
      if (!first || known_type(data_byte)) begin
        type_r   <= type_nxt;
        hdr_r    <= hdr_nxt;
        pkt_r    <= pkt_nxt;
        opc_r    <= opc_nxt;
        len_lo_r <= len_lo_nxt;
        magic_r  <= magic_nxt;
        alive_r  <= alive_nxt;
      end
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.is_last |=> cnt_r == '0)
    else $error("count not cleared after last beat");

  a_verdict_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    res.verdict != VERD_FORWARD |-> res.is_last)
    else $error("verdict on a beat that is not last");

  a_drop_keeps_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.verdict == VERD_DROPPED |=> cnt_r == '0 && $stable(type_r))
    else $error("dropped byte changed packet state");

endmodule

### hw/rtl/h4_uart_packet_deframer.sv
// H4 UART packet deframer top: input register, packet decoder, result register.
// Depends on h4d_pkg and h4d_decoder.
//
//   channel | ports                               | dir | handshake
//   input   | in_data_byte                        | in  | in_valid / in_ready
//   result  | out_byte_out .. out_verdict         | out | out_valid / out_ready
//
// One beat per cycle sustained while out_ready stays high; an accepted byte goes first into
// the input register, then is decoded into the result register, from which it leaves.
// The input register drains whenever the result register is empty or being taken,
// so a stall on the result side backs up one beat before in_ready drops.
// rst_n is synchronous: both registers go empty and the decoder waits for a type byte.
`timescale 1ns / 1ps

module h4_uart_packet_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte_out,
  output logic [2:0]                out_packet_type,
  output logic [h4d_pkg::IDX_W-1:0] out_byte_index,
  output logic                      out_in_header,
  output logic                      out_is_last,
  output logic [3:0]                out_verdict
);
  import h4d_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  result_t    res;
  logic       s2_free;
  logic       adv;
  logic       in_fire;

  assign s2_free  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_free;
  assign adv      = s1_valid_r && s2_free;
  assign in_fire  = in_valid && in_ready;

  h4d_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .data_byte (s1_data_r),
    .res       (res)
  );

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_data_r <= in_data_byte;
    if (adv) out_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = out_r.byte_out;
  assign out_packet_type = out_r.packet_type;
  assign out_byte_index  = out_r.byte_index;
  assign out_in_header   = out_r.in_header;
  assign out_is_last     = out_r.is_last;
  assign out_verdict     = out_r.verdict;

  a_hold_input_beat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register lost a beat under stall");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("decoded beat not loaded into result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("registers not empty after reset");

endmodule

### dv/h4_uart_packet_deframer_tb.sv
// Self-checking testbench for h4_uart_packet_deframer: H4 byte stream in, tagged echo out.
// Depends on h4d_pkg and the deframer RTL; the echo predictor lives in a small scoreboard class.
`timescale 1ns / 1ps

module h4_uart_packet_deframer_tb;
  import h4d_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned RANDOM_BYTES = 1800;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [7:0] NEG_FRAME [12] = '{
    8'h06, 8'h0a, 8'h00, 8'ha0, 8'h01, 8'h00, 8'h00, 8'h4c, 8'h00, 8'h96, 8'h00, 8'h00
  };

  class h4_echo_board;
    int unsigned byte_count;
    int unsigned hdr_total;
    int unsigned pkt_total;
    logic [2:0]  cur_type;
    logic [15:0] opcode;
    logic [7:0]  len_low;
    bit          magic_ok;
    bit          alive_ok;
    result_t     echo_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned packets;
    int unsigned dropped;
    int unsigned verdict_hits[16];

    function new();
      byte_count = 0;
      cur_type   = TYPE_NONE;
      hdr_total  = HDR_UNKNOWN;
      pkt_total  = PKT_UNKNOWN;
      opcode     = '0;
      len_low    = '0;
      magic_ok   = 1'b1;
      alive_ok   = 1'b1;
      mismatches = 0;
      checked    = 0;
      packets    = 0;
      dropped    = 0;
      foreach (verdict_hits[i]) verdict_hits[i] = 0;
    endfunction

    function bit is_type(logic [7:0] b);
      case (b)
        {5'd0, TYPE_CMD}, {5'd0, TYPE_ACL}, {5'd0, TYPE_SCO},
        {5'd0, TYPE_EVT}, {5'd0, TYPE_NEG}, {5'd0, TYPE_ALIVE}: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function logic [3:0] packet_verdict();
      case (cur_type)
        TYPE_CMD: begin
          if (opcode[15:10] != OGF_VENDOR) return VERD_FORWARD;
          if (opcode[9:0] == OCF_ACK_A || opcode[9:0] == OCF_ACK_B) return VERD_VEND_ACK;
          return VERD_VEND_UNK;
        end
        TYPE_EVT:   return VERD_HOST_EVT;
        TYPE_NEG:   return (hdr_total == NEG_MAGIC_LEN && magic_ok) ? VERD_NEG_OK : VERD_NEG_BAD;
        TYPE_ALIVE: return alive_ok ? VERD_ALIVE_OK : VERD_ALIVE_BAD;
        default:    return VERD_FORWARD;
      endcase
    endfunction

    // Advance the packet tracker by one accepted byte and queue its echo.
    function void take_byte(logic [7:0] b);
      result_t     r;
      int unsigned idx;
      int unsigned n;
      int unsigned dlen;
      idx = byte_count;
      n = idx + 1;
      r = '0;
      r.byte_out = b;
      r.byte_index = idx[IDX_W-1:0];
      if (idx == 0) begin
        r.in_header = 1'b1;
        if (!is_type(b)) begin
          r.packet_type = TYPE_NONE;
          r.is_last = 1'b1;
          r.verdict = VERD_DROPPED;
          dropped++;
          verdict_hits[VERD_DROPPED]++;
        end else begin
          cur_type   = b[2:0];
          hdr_total  = HDR_UNKNOWN;
          pkt_total  = PKT_UNKNOWN;
          opcode     = '0;
          len_low    = '0;
          magic_ok   = (b == NEG_FRAME[0]);
          alive_ok   = 1'b1;
          byte_count = 1;
          r.packet_type = cur_type;
        end
        echo_q.push_back(r);
        return;
      end

      if (idx == 1) opcode[7:0] = b;
      if (idx == 2) opcode[15:8] = b;
      if (idx == 3) len_low = b;
      if (idx >= 12 || b != NEG_FRAME[idx % 12]) magic_ok = 1'b0;
      if ((idx == 2 && b != ALIVE_BYTE2) || (idx == 3 && b != ALIVE_BYTE3)) alive_ok = 1'b0;

      if (idx == 1) begin
        case (cur_type)
          TYPE_EVT: hdr_total = 3;
          TYPE_ACL: hdr_total = 5;
          TYPE_NEG: hdr_total = b + 2;
          default:  hdr_total = 4;
        endcase
      end

      if (n == hdr_total) begin
        case (cur_type)
          TYPE_CMD: dlen = (opcode == OPC_VENDOR_PAD) ? (((b + 1) >> 1) << 1) : b;
          TYPE_EVT: dlen = b;
          TYPE_ACL: dlen = {b, len_low};
          TYPE_SCO: dlen = b;
          default:  dlen = 0;
        endcase
        pkt_total = hdr_total + dlen;
      end

      r.packet_type = cur_type;
      r.in_header = (idx < hdr_total);
      if (n == pkt_total) begin
        r.is_last = 1'b1;
        r.verdict = packet_verdict();
        byte_count = 0;
        packets++;
        verdict_hits[r.verdict]++;
      end else begin
        byte_count = n % (1 << IDX_W);
      end
      echo_q.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%t %s: want byte %h type %0d idx %0d hdr %b last %b verd %0d, got byte %h type %0d idx %0d hdr %b last %b verd %0d",
                 $realtime, what, want.byte_out, want.packet_type, want.byte_index,
                 want.in_header, want.is_last, want.verdict, got.byte_out, got.packet_type,
                 got.byte_index, got.in_header, got.is_last, got.verdict);
    endfunction

    function void match_echo(result_t got);
      result_t want;
      if (echo_q.size() == 0) begin
        report("echo with nothing pending", '0, got);
        return;
      end
      want = echo_q.pop_front();
      checked++;
      if (got.byte_out != want.byte_out || got.packet_type != want.packet_type ||
          got.byte_index != want.byte_index || got.in_header != want.in_header ||
          got.is_last != want.is_last || got.verdict != want.verdict)
        report("echo mismatch", want, got);
    endfunction

    function int unsigned pending();
      return echo_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_data_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_byte_out;
  logic [2:0]          out_packet_type;
  logic [IDX_W-1:0]    out_byte_index;
  logic                out_in_header;
  logic                out_is_last;
  logic [3:0]          out_verdict;

  h4_echo_board board = new();
  int unsigned  sent = 0;
  int unsigned  quiet_left = 0;

  h4_uart_packet_deframer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_out   (out_byte_out),
    .out_packet_type(out_packet_type),
    .out_byte_index (out_byte_index),
    .out_in_header  (out_in_header),
    .out_is_last    (out_is_last),
    .out_verdict    (out_verdict)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_len(int unsigned short_max, int unsigned long_max);
    if ($urandom_range(0, 19) != 0) return $urandom_range(0, short_max);
    return $urandom_range(0, long_max);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.take_byte(b);
    sent++;
  endtask

  task automatic send_body(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // Hold the sender off until every queued echo has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [15:0] op, input logic [7:0] plen);
    send_byte(8'(TYPE_CMD));
    send_byte(op[7:0]);
    send_byte(op[15:8]);
    send_byte(plen);
    send_body(op == OPC_VENDOR_PAD ? ((plen + 1) >> 1) << 1 : plen);
  endtask

  task automatic send_acl(input logic [15:0] handle, input logic [15:0] dlen);
    send_byte(8'(TYPE_ACL));
    send_byte(handle[7:0]);
    send_byte(handle[15:8]);
    send_byte(dlen[7:0]);
    send_byte(dlen[15:8]);
    send_body(dlen);
  endtask

  task automatic send_sco(input logic [15:0] handle, input logic [7:0] dlen);
    send_byte(8'(TYPE_SCO));
    send_byte(handle[7:0]);
    send_byte(handle[15:8]);
    send_byte(dlen);
    send_body(dlen);
  endtask

  task automatic send_evt(input logic [7:0] code, input logic [7:0] plen);
    send_byte(8'(TYPE_EVT));
    send_byte(code);
    send_byte(plen);
    send_body(plen);
  endtask

  task automatic send_neg(input logic [7:0] len);
    send_byte(8'(TYPE_NEG));
    send_byte(len);
    send_body(len);
  endtask

  // Flip the byte at bad_pos when bad_pos is in range; framing stays intact if it is past the length field.
  task automatic send_neg_magic(input int bad_pos);
    logic [7:0] v;
    for (int i = 0; i < 12; i++) begin
      v = NEG_FRAME[i];
      if (i == bad_pos) v = v ^ 8'($urandom_range(1, 255));
      send_byte(v);
    end
  endtask

  task automatic send_alive(input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
    send_byte(8'(TYPE_ALIVE));
    send_byte(b1);
    send_byte(b2);
    send_byte(b3);
  endtask

  task automatic send_random_packet();
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      k = $urandom_range(0, 9);
      if (k < 3)
        send_cmd(OPC_VENDOR_PAD, 8'(pick_len(9, 255)));
      else if (k < 5)
        send_cmd({OGF_VENDOR, ($urandom_range(0, 1) != 0) ? OCF_ACK_A : OCF_ACK_B},
                 8'(pick_len(8, 255)));
      else if (k < 7)
        send_cmd({OGF_VENDOR, 10'($urandom)}, 8'(pick_len(8, 255)));
      else
        send_cmd(16'($urandom), 8'(pick_len(8, 255)));
    end else if (pick < 35) begin
      send_acl(16'($urandom), 16'(pick_len(12, 700)));
    end else if (pick < 47) begin
      send_sco(16'($urandom), 8'(pick_len(10, 255)));
    end else if (pick < 59) begin
      send_evt(8'($urandom), 8'(pick_len(9, 255)));
    end else if (pick < 77) begin
      k = $urandom_range(0, 9);
      if (k < 6) send_neg_magic(-1);
      else if (k < 8) send_neg_magic($urandom_range(2, 11));
      else send_neg(8'(pick_len(20, 255)));
    end else if (pick < 91) begin
      if ($urandom_range(0, 9) < 7)
        send_alive(8'($urandom), ALIVE_BYTE2, ALIVE_BYTE3);
      else
        send_alive(8'($urandom), ($urandom_range(0, 1) != 0) ? ALIVE_BYTE2 : 8'($urandom),
                   8'($urandom));
    end else begin
      // stray byte where a type byte belongs
      do b = 8'($urandom); while (board.is_type(b));
      send_byte(b);
    end
  endtask

  // Result side: stall in gaps, otherwise take beats for a stretch.
  initial begin
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20))
        @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.match_echo(result_t'({out_byte_out, out_packet_type, out_byte_index,
                                  out_in_header, out_is_last, out_verdict}));
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no beat moved for %0d cycles, %0d echoes pending", IDLE_LIMIT,
             board.pending());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned random_start;
    bit          mid_drained;
    mid_drained = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray type bytes at both extremes, empty and magic neg, the special verdicts
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h05);
    send_neg(8'h00);
    send_neg_magic(-1);
    send_alive(8'hff, ALIVE_BYTE2, ALIVE_BYTE3);
    send_evt(8'h00, 8'h00);
    send_cmd(OPC_VENDOR_PAD, 8'h01);
    send_cmd({OGF_VENDOR, OCF_ACK_B}, 8'h00);
    drain();

    random_start = sent;
    while (sent - random_start < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) quiet_left = $urandom_range(20, 80);
      if (!mid_drained && sent - random_start >= RANDOM_BYTES / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      send_random_packet();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d bytes: %0d packets closed, %0d stray type bytes dropped, %0d echoes checked",
             sent, board.packets, board.dropped, board.checked);
    $display("verdicts: fwd %0d, vendor ack/unk %0d/%0d, neg ok/bad %0d/%0d, alive ok/bad %0d/%0d, host evt %0d",
             board.verdict_hits[VERD_FORWARD], board.verdict_hits[VERD_VEND_ACK],
             board.verdict_hits[VERD_VEND_UNK], board.verdict_hits[VERD_NEG_OK],
             board.verdict_hits[VERD_NEG_BAD], board.verdict_hits[VERD_ALIVE_OK],
             board.verdict_hits[VERD_ALIVE_BAD], board.verdict_hits[VERD_HOST_EVT]);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d echoes never seen", board.mismatches, board.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
